@@ hw/rtl/ime_pkg.sv @@
// Shared types, constants and message layout table for the ITCH field extractor.
package ime_pkg;

  // Status codes of a result
  localparam logic [1:0] ST_FIELD   = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  localparam int MaxMsgBytes = 64;
  localparam int PosW        = $clog2(MaxMsgBytes);
  localparam int MaxFields   = 17;
  localparam int FifoDepth   = 4;
  localparam int FifoPtrW    = $clog2(FifoDepth);

  // End of the first field, one past its last byte (type byte plus 2-byte locate)
  localparam logic [PosW:0] FirstEnd = (PosW+1)'(3);

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [4:0]  field_index;
    logic [63:0] field_value;
    logic [3:0]  field_bytes;
    logic [1:0]  status;
    logic        last;
  } ime_result_t;

  // Field widths per type, field 0 in the lowest nibble; zero means no field
  function automatic logic [4*MaxFields-1:0] lay_row(input logic [7:0] code);
    logic [4*MaxFields-1:0] r;
    r = '0;
    case (code)
      8'h53: r = 68'h1622;                // S
      8'h52: r = 68'h14111112114118622;   // R
      8'h48: r = 68'h4118622;             // H
      8'h59: r = 68'h18622;               // Y
      8'h4C: r = 68'h11184622;            // L
      8'h56: r = 68'h888622;              // V
      8'h57: r = 68'h1622;                // W
      8'h4B: r = 68'h4148622;             // K
      8'h4A: r = 68'h44448622;            // J
      8'h68: r = 68'h118622;              // h
      8'h41: r = 68'h48418622;            // A
      8'h46: r = 68'h448418622;           // F
      8'h45: r = 68'h848622;              // E
      8'h43: r = 68'h41848622;            // C
      8'h58: r = 68'h48622;               // X
      8'h44: r = 68'h8622;                // D
      8'h55: r = 68'h4488622;             // U
      8'h50: r = 68'h848418622;           // P
      8'h51: r = 68'h18488622;            // Q
      8'h42: r = 68'h8622;                // B
      8'h49: r = 68'h114448188622;        // I
      8'h4E: r = 68'h18622;               // N
      8'h4F: r = 68'h44844418622;         // O
      default: r = '0;
    endcase
    return r;
  endfunction

  // Width in bytes of field idx of a type, zero past the last field
  function automatic logic [3:0] lay_width(input logic [7:0] code, input logic [4:0] idx);
    logic [4*MaxFields-1:0] row;
    row = lay_row(code);
    if (idx < 5'(MaxFields)) begin
      return row[4*idx +: 4];
    end
    return 4'd0;
  endfunction

endpackage

@@ hw/rtl/ime_parser.sv @@
// Byte position tracking, field assembly and status generation.
module ime_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_buffer,
  output logic                 push_a,
  output logic                 push_b,
  output ime_pkg::ime_result_t res_a,
  output ime_pkg::ime_result_t res_b
);

  logic [ime_pkg::PosW-1:0] byte_position, byte_position_next;
  logic [7:0]               type_register, type_register_next;
  logic [63:0]              field_accumulator, field_accumulator_next;
  logic [4:0]               field_counter, field_counter_next;
  logic                     type_known, type_known_next;
  logic [ime_pkg::PosW:0]   field_end, field_end_next;

  logic [3:0]  cur_w;
  logic [3:0]  nxt_w;
  logic [3:0]  left_w;
  logic [63:0] acc_sh;
  logic        fld_done;
  logic [1:0]  st;
  ime_pkg::ime_result_t fld_res, st_res;

  assign cur_w  = ime_pkg::lay_width(type_register, field_counter);
  assign nxt_w  = ime_pkg::lay_width(type_register, field_counter + 5'd1);
  assign acc_sh = {field_accumulator[55:0], data_byte};

  // Per-byte state update
  always_comb begin
    byte_position_next     = byte_position;
    type_register_next     = type_register;
    field_accumulator_next = field_accumulator;
    field_counter_next     = field_counter;
    type_known_next        = type_known;
    field_end_next         = field_end;
    fld_done               = 1'b0;
    if (byte_position == '0) begin
      type_register_next     = data_byte;
      type_known_next        = (ime_pkg::lay_width(data_byte, 5'd0) != 4'd0);
      field_counter_next     = '0;
      field_accumulator_next = '0;
      field_end_next         = ime_pkg::FirstEnd;
    end else if (type_known && cur_w != 4'd0) begin
      field_accumulator_next = acc_sh;
      if ({1'b0, byte_position} + 1'b1 == field_end) begin
        fld_done               = 1'b1;
        field_accumulator_next = '0;
        field_counter_next     = field_counter + 5'd1;
        field_end_next         = field_end + (ime_pkg::PosW+1)'(nxt_w);
      end
    end
    if (byte_position != ime_pkg::PosW'(ime_pkg::MaxMsgBytes - 1)) begin
      byte_position_next = byte_position + 1'b1;
    end
    if (end_of_buffer) begin
      byte_position_next     = '0;
      field_counter_next     = '0;
      field_accumulator_next = '0;
      type_known_next        = 1'b0;
    end
  end

  // Status of the message at its final byte
  assign left_w = ime_pkg::lay_width(type_register_next,
                                     fld_done ? field_counter + 5'd1 : field_counter);
  always_comb begin
    if (!(byte_position == '0 ? (ime_pkg::lay_width(data_byte, 5'd0) != 4'd0)
                              : type_known)) begin
      st = ime_pkg::ST_UNKNOWN;
    end else if (left_w != 4'd0) begin
      st = ime_pkg::ST_SHORT;
    end else begin
      st = ime_pkg::ST_OK;
    end
  end

  // Result assembly; a field result goes ahead of the status
  always_comb begin
    fld_res.msg_type    = type_register_next;
    fld_res.field_index = field_counter;
    fld_res.field_value = acc_sh;
    fld_res.field_bytes = cur_w;
    fld_res.status      = ime_pkg::ST_FIELD;
    fld_res.last        = 1'b0;
    st_res.msg_type     = type_register_next;
    st_res.field_index  = '0;
    st_res.field_value  = '0;
    st_res.field_bytes  = '0;
    st_res.status       = st;
    st_res.last         = 1'b1;
    push_a = accept && (fld_done || end_of_buffer);
    push_b = accept && fld_done && end_of_buffer;
    res_a  = fld_done ? fld_res : st_res;
    res_b  = st_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      type_register     <= '0;
      field_accumulator <= '0;
      field_counter     <= '0;
      type_known        <= 1'b0;
      field_end         <= ime_pkg::FirstEnd;
    end else if (accept) begin
      byte_position     <= byte_position_next;
      type_register     <= type_register_next;
      field_accumulator <= field_accumulator_next;
      field_counter     <= field_counter_next;
      type_known        <= type_known_next;
      field_end         <= field_end_next;
    end
  end

endmodule

@@ hw/rtl/ime_out_fifo.sv @@
// Small result queue taking up to two results per cycle and giving one per cycle while out_ready is high.
module ime_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_a,
  input  logic                 push_b,
  input  ime_pkg::ime_result_t res_a,
  input  ime_pkg::ime_result_t res_b,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ime_pkg::ime_result_t out_res
);

  ime_pkg::ime_result_t entries [ime_pkg::FifoDepth];
  logic [ime_pkg::FifoPtrW-1:0] wr_ptr, wr_ptr_next;
  logic [ime_pkg::FifoPtrW-1:0] rd_ptr;
  logic [ime_pkg::FifoPtrW:0]   count, count_next;
  logic                         pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_res   = entries[rd_ptr];
  // Room for two results regardless of this cycle's pop
  assign room      = (count <= (ime_pkg::FifoPtrW+1)'(ime_pkg::FifoDepth - 2));

  always_comb begin
    wr_ptr_next = wr_ptr + ime_pkg::FifoPtrW'(push_a) + ime_pkg::FifoPtrW'(push_b);
    count_next  = count + (ime_pkg::FifoPtrW+1)'(push_a) + (ime_pkg::FifoPtrW+1)'(push_b)
                  - (ime_pkg::FifoPtrW+1)'(pop);
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_a) begin
      entries[wr_ptr] <= res_a;
    end
    if (push_b) begin
      entries[wr_ptr + 1'b1] <= res_b;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/itch_message_field_extractor.sv @@
// Top level of the ITCH 5.0 message field extractor.
// One message byte is taken per request, one per cycle while the result queue has room
// for two results; each byte is handled by the position counter and the layout table
// lookup. A field result is queued on the cycle its last byte arrives, and the final byte
// of a buffer also queues a status result (ok, unknown type or short) with last set.
// Fields of a message whose status is not ok must be dropped by the consumer. Results
// leave a four-entry queue; input keeps flowing while at most two results wait to be taken.
module itch_message_field_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  msg_type,
  output logic [4:0]  field_index,
  output logic [63:0] field_value,
  output logic [3:0]  field_bytes,
  output logic [1:0]  status,
  output logic        last
);

  logic                 push_a, push_b, room;
  ime_pkg::ime_result_t res_a, res_b, out_res;

  assign in_ready = room;

  // Parser
  ime_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_valid && room),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .push_a        (push_a),
    .push_b        (push_b),
    .res_a         (res_a),
    .res_b         (res_b)
  );

  // Result queue
  ime_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_a    (push_a),
    .push_b    (push_b),
    .res_a     (res_a),
    .res_b     (res_b),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign msg_type    = out_res.msg_type;
  assign field_index = out_res.field_index;
  assign field_value = out_res.field_value;
  assign field_bytes = out_res.field_bytes;
  assign status      = out_res.status;
  assign last        = out_res.last;

endmodule
